### rtl/websocket_frame_parser_macros.svh
// assertion macros shared by the frame parser rtl
// expects a clock named clk and an active-low async reset named arst_n in scope
`ifndef WEBSOCKET_FRAME_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define WSFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define WSFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wsfp_pkg.sv
// shared types, codes and helpers for the websocket frame parser
// no dependencies
`default_nettype none

package wsfp_pkg;

	// parse phases
	localparam logic [2:0] PH_OPCODE = 3'd0;
	localparam logic [2:0] PH_LENGTH = 3'd1;
	localparam logic [2:0] PH_EXT_HI = 3'd2;
	localparam logic [2:0] PH_EXT_LO = 3'd3;
	localparam logic [2:0] PH_KEY    = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_SKIP   = 3'd6;

	// opcodes of interest
	localparam logic [3:0] OPC_CLOSE = 4'd8;
	localparam logic [3:0] OPC_PING  = 4'd9;

	// length field codes
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// reply codes
	localparam logic [1:0] REPLY_NONE  = 2'd0;
	localparam logic [1:0] REPLY_PONG  = 2'd1;
	localparam logic [1:0] REPLY_CLOSE = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_CUT   = 2'd1;
	localparam logic [1:0] STAT_LEN64 = 2'd2;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic [3:0] frame_opcode;
		logic       frame_last;
		logic [1:0] reply_kind;
		logic [1:0] frame_status;
	} wsfp_res_t;

	function automatic logic [1:0] reply_for(input logic [3:0] opc);
		logic [1:0] r;
		r = REPLY_NONE;
		if (opc == OPC_PING)
			r = REPLY_PONG;
		else if (opc == OPC_CLOSE)
			r = REPLY_CLOSE;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/websocket_frame_parser.sv
// websocket frame parser top level: input register, parse core, result register
// depends on wsfp_pkg and wsfp_parse
//
// usage: feed received bytes on rx_byte with chunk_end high on the last byte of
// each received chunk; one frame is parsed per chunk. the parser reads the opcode
// byte, the length byte, a 16-bit extended length when the length field is 126,
// and four key bytes when the mask bit is set, then gives each payload byte
// unmasked, one result per byte. the last result of a frame has frame_last high
// and carries frame_status (ok, cut short by the chunk end, or the unsupported
// 64-bit length) and reply_kind (pong for ping, close echo for close). an empty
// frame, an early chunk end in the header or a 64-bit length gives a single
// result with payload_valid low. bytes after a complete frame give no result.
// rate: one byte per clock sustained, with in_ready staying high while the
// result register is free or being drained; a result passes the input register,
// then the result register after the combinational parse step. a byte that
// yields no result still takes its slot.
`default_nettype none

module websocket_frame_parser import wsfp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       chunk_end,
	// result channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      payload_byte,
	output logic            payload_valid,
	output logic [3:0]      frame_opcode,
	output logic            frame_last,
	output logic [1:0]      reply_kind,
	output logic [1:0]      frame_status
);

	// input register stage
	logic       item_valid_s1;
	logic [7:0] rx_byte_s1;
	logic       chunk_end_s1;

	// result register
	logic       out_valid_q;
	wsfp_res_t  res_q;

	logic       advance;
	logic       res_fire;
	wsfp_res_t  res;

	// the held byte is parsed when the result slot is empty or being drained
	assign advance  = item_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1   <= rx_byte;
			chunk_end_s1 <= chunk_end;
		end
	end

	wsfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (rx_byte_s1),
		.chunk_end (chunk_end_s1),
		.res_fire  (res_fire),
		.res       (res)
	);

	// result register: loads on a producing step, empties on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = res_q.payload_byte;
	assign payload_valid = res_q.payload_valid;
	assign frame_opcode  = res_q.frame_opcode;
	assign frame_last    = res_q.frame_last;
	assign reply_kind    = res_q.reply_kind;
	assign frame_status  = res_q.frame_status;

endmodule

`default_nettype wire

### rtl/wsfp_parse.sv
// header parse state and payload unmasking, one byte per step
// depends on wsfp_pkg and websocket_frame_parser_macros.svh
`default_nettype none
`include "websocket_frame_parser_macros.svh"

module wsfp_parse import wsfp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire logic [7:0] rx_byte,
	input  wire logic      chunk_end,
	output logic           res_fire,
	output wsfp_res_t      res
);

	logic [2:0]       phase_q, phase_d;
	logic [3:0]       opcode_q, opcode_d;
	logic             masked_q, masked_d;
	logic [15:0]      length_q, length_d;
	logic [3:0][7:0]  key_q, key_d;
	logic [15:0]      index_q, index_d;

	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_valid;
	logic       emit_last;
	logic [1:0] emit_status;
	logic       hdr_done;
	logic       cut;
	logic [7:0] unmasked;
	logic       data_last;

	assign unmasked  = masked_q ? (rx_byte ^ key_q[index_q[1:0]]) : rx_byte;
	assign data_last = ({1'b0, index_q} + 17'd1) >= {1'b0, length_q};

	always_comb begin
		phase_d     = phase_q;
		opcode_d    = opcode_q;
		masked_d    = masked_q;
		length_d    = length_q;
		key_d       = key_q;
		index_d     = index_q;
		emit        = 1'b0;
		emit_byte   = 8'h00;
		emit_valid  = 1'b0;
		emit_last   = 1'b0;
		emit_status = STAT_OK;
		hdr_done    = 1'b0;
		cut         = 1'b0;
		if (step) begin
			case (phase_q)
				PH_OPCODE: begin
					opcode_d = rx_byte[3:0];
					masked_d = 1'b0;
					length_d = 16'h0000;
					index_d  = 16'h0000;
					key_d    = '0;
					phase_d  = PH_LENGTH;
					cut      = chunk_end;
				end
				PH_LENGTH: begin
					masked_d = rx_byte[7];
					if (rx_byte[6:0] == LEN_EXT64) begin
						phase_d     = chunk_end ? PH_OPCODE : PH_SKIP;
						emit        = 1'b1;
						emit_last   = 1'b1;
						emit_status = STAT_LEN64;
					end else if (rx_byte[6:0] == LEN_EXT16) begin
						phase_d = PH_EXT_HI;
						cut     = chunk_end;
					end else begin
						length_d = {9'h000, rx_byte[6:0]};
						if (rx_byte[7]) begin
							index_d = 16'h0000;
							phase_d = PH_KEY;
							cut     = chunk_end;
						end else begin
							hdr_done = 1'b1;
						end
					end
				end
				PH_EXT_HI: begin
					length_d = {rx_byte, 8'h00};
					phase_d  = PH_EXT_LO;
					cut      = chunk_end;
				end
				PH_EXT_LO: begin
					length_d = length_q | {8'h00, rx_byte};
					if (masked_q) begin
						index_d = 16'h0000;
						phase_d = PH_KEY;
						cut     = chunk_end;
					end else begin
						hdr_done = 1'b1;
					end
				end
				PH_KEY: begin
					key_d[index_q[1:0]] = rx_byte;
					index_d = index_q + 16'd1;
					if (index_q[1:0] == 2'd3)
						hdr_done = 1'b1;
					else
						cut = chunk_end;
				end
				PH_DATA: begin
					emit       = 1'b1;
					emit_byte  = unmasked;
					emit_valid = 1'b1;
					if (data_last) begin
						phase_d   = chunk_end ? PH_OPCODE : PH_SKIP;
						emit_last = 1'b1;
					end else if (chunk_end) begin
						phase_d     = PH_OPCODE;
						emit_last   = 1'b1;
						emit_status = STAT_CUT;
					end else begin
						index_d = index_q + 16'd1;
					end
				end
				default: begin
					if (chunk_end)
						phase_d = PH_OPCODE;
				end
			endcase

			// header complete: empty frame ends here, else payload follows
			if (hdr_done) begin
				index_d = 16'h0000;
				if (length_d == 16'h0000) begin
					phase_d   = chunk_end ? PH_OPCODE : PH_SKIP;
					emit      = 1'b1;
					emit_last = 1'b1;
				end else begin
					phase_d = PH_DATA;
					cut     = chunk_end;
				end
			end

			if (cut) begin
				phase_d     = PH_OPCODE;
				emit        = 1'b1;
				emit_byte   = 8'h00;
				emit_valid  = 1'b0;
				emit_last   = 1'b1;
				emit_status = STAT_CUT;
			end
		end
	end

	always_comb begin
		res_fire           = emit;
		res.payload_byte   = emit_valid ? emit_byte : 8'h00;
		res.payload_valid  = emit_valid;
		res.frame_opcode   = opcode_d;
		res.frame_last     = emit_last;
		res.reply_kind     = (emit_last && emit_status != STAT_LEN64) ?
			reply_for(opcode_d) : REPLY_NONE;
		res.frame_status   = emit_last ? emit_status : STAT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			opcode_q <= 4'h0;
			masked_q <= 1'b0;
			length_q <= 16'h0000;
			key_q    <= '0;
			index_q  <= 16'h0000;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			length_q <= length_d;
			key_q    <= key_d;
			index_q  <= index_d;
		end
	end

	`WSFP_ASSERT_NOW(a_status_only_last, res_fire && res.frame_status != STAT_OK, res.frame_last, "status given on a non-final result")
	`WSFP_ASSERT_NOW(a_payload_in_data, res_fire && res.payload_valid, phase_q == PH_DATA, "payload byte outside the data phase")
	`WSFP_ASSERT_NOW(a_key_index_range, phase_q == PH_KEY, index_q < 16'd4, "key index past four bytes")
	`WSFP_ASSERT_NEXT(a_chunk_end_restart, step && chunk_end, phase_q == PH_OPCODE, "chunk end did not return to opcode phase")

endmodule

`default_nettype wire
